/* rtl/ssadlp_pkg.sv */
// shared types, constants and helper functions for the dialogue line parser
// no dependencies; imported by ssa_dialogue_line_parser_top
`timescale 1ns / 1ps
`default_nettype none

package ssadlp_pkg;

  localparam int MAX_LINE_CHARS = 256;
  localparam int MAX_FIELDS     = 256;

  localparam int LEN_W     = $clog2(MAX_LINE_CHARS);
  localparam int FIELD_W   = $clog2(MAX_FIELDS);
  localparam int COL_W     = 8;
  localparam int FCNT_W    = 9;
  localparam int CODE_W    = 16;
  localparam int NUM_W     = 17;
  localparam int SCALE_W   = 32;
  localparam int TIME_W    = NUM_W + SCALE_W;
  localparam int DUR_W     = TIME_W + 1;
  localparam int PART_W    = 3;
  localparam int DIG_W     = 3;
  localparam int POS_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [POS_W-1:0]  PREFIX_LEN = POS_W'(10);
  localparam logic [PART_W-1:0] PART_LAST  = PART_W'(3);
  localparam logic [PART_W-1:0] PART_DONE  = PART_W'(4);
  localparam logic [DIG_W-1:0]  MAX_DIGITS = DIG_W'(5);

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COLUMN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_COLUMN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLUMN  = 2'd3;

  localparam logic [FCNT_W-1:0] RST_FIELD_COUNT  = 9'd10;
  localparam logic [COL_W-1:0]  RST_START_COLUMN = 8'd1;
  localparam logic [COL_W-1:0]  RST_END_COLUMN   = 8'd2;
  localparam logic [COL_W-1:0]  RST_TEXT_COLUMN  = 8'd9;

  localparam logic [CODE_W-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CODE_W-1:0] CH_RBRACE = 16'h007D;
  localparam logic [CODE_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CODE_W-1:0] CH_LOW_N  = 16'h006E;
  localparam logic [CODE_W-1:0] CH_UP_N   = 16'h004E;
  localparam logic [CODE_W-1:0] CH_COMMA  = 16'h002C;
  localparam logic [CODE_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [CODE_W-1:0] CH_COLON  = 16'h003A;
  localparam logic [CODE_W-1:0] CH_DOT    = 16'h002E;
  localparam logic [CODE_W-1:0] CH_ZERO   = 16'h0030;
  localparam logic [CODE_W-1:0] CH_NINE   = 16'h0039;
  localparam logic [CODE_W-1:0] CH_UP_A   = 16'h0041;
  localparam logic [CODE_W-1:0] CH_UP_Z   = 16'h005A;
  localparam logic [CODE_W-1:0] CASE_GAP  = 16'h0020;

  localparam logic [SCALE_W-1:0] US_PER_HOUR = 32'd3600000000;
  localparam logic [SCALE_W-1:0] US_PER_MIN  = 32'd60000000;
  localparam logic [SCALE_W-1:0] US_PER_SEC  = 32'd1000000;
  localparam logic [SCALE_W-1:0] US_PER_CS   = 32'd10000;

  typedef enum logic [1:0] {
    RK_TEXT   = 2'd0,
    RK_BREAK  = 2'd1,
    RK_RECORD = 2'd2
  } rkind_t;

  typedef enum logic [2:0] {
    TM_NORMAL = 3'b001,
    TM_BRACE  = 3'b010,
    TM_ESCAPE = 3'b100
  } tmode_t;

  typedef struct packed {
    logic [PART_W-1:0] part;
    logic [NUM_W-1:0]  number;
    logic [DIG_W-1:0]  digits;
    logic              seen;
    logic              error;
  } stamp_t;

  typedef struct packed {
    logic             en;
    logic [NUM_W-1:0] number;
    logic [1:0]       part;
  } close_t;

  typedef struct packed {
    stamp_t s;
    close_t cl;
  } stamp_res_t;

  typedef struct packed {
    logic              brk_first;
    rkind_t            kind;
    logic [CODE_W-1:0] code;
    logic              valid;
  } entry_t;

  typedef struct packed {
    logic              brk_first;
    rkind_t            kind;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] start;
    logic [DUR_W-1:0]  dur;
    logic              valid;
  } fifo_entry_t;

  function automatic logic [CODE_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [CODE_W-1:0] c;
    unique case (pos)
      4'd0:    c = 16'h0064;
      4'd1:    c = 16'h0069;
      4'd2:    c = 16'h0061;
      4'd3:    c = 16'h006C;
      4'd4:    c = 16'h006F;
      4'd5:    c = 16'h0067;
      4'd6:    c = 16'h0075;
      4'd7:    c = 16'h0065;
      4'd8:    c = 16'h003A;
      4'd9:    c = 16'h0020;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [SCALE_W-1:0] part_scale(input logic [1:0] part);
    logic [SCALE_W-1:0] s;
    unique case (part)
      2'd0: s = US_PER_HOUR;
      2'd1: s = US_PER_MIN;
      2'd2: s = US_PER_SEC;
      2'd3: s = US_PER_CS;
    endcase
    return s;
  endfunction

  function automatic stamp_res_t stamp_close(input stamp_t s);
    stamp_res_t r;
    r.cl.en     = 1'b1;
    r.cl.number = s.number;
    r.cl.part   = s.part[1:0];
    r.s         = s;
    r.s.part    = s.part + PART_W'(1);
    r.s.number  = '0;
    r.s.digits  = '0;
    r.s.seen    = 1'b0;
    return r;
  endfunction

  function automatic stamp_res_t stamp_char(input stamp_t s, input logic [CODE_W-1:0] c);
    stamp_res_t        r;
    logic [CODE_W-1:0] sep;
    r.s  = s;
    r.cl = '0;
    sep  = (s.part == PART_W'(2)) ? CH_DOT : CH_COLON;
    if (!s.error && s.part < PART_DONE) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (s.digits >= MAX_DIGITS) begin
          r.s.error = 1'b1;
        end else begin
          r.s.number = NUM_W'(s.number * NUM_W'(10)) + NUM_W'(c[3:0]);
          r.s.digits = s.digits + DIG_W'(1);
          r.s.seen   = 1'b1;
        end
      end else if (c == CH_SPACE && !s.seen) begin
        r.s = s;
      end else if (!s.seen) begin
        r.s.error = 1'b1;
      end else if (s.part == PART_LAST || c == sep) begin
        r = stamp_close(s);
      end else begin
        r.s.error = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic stamp_res_t stamp_end(input stamp_t s);
    stamp_res_t r;
    r.s  = s;
    r.cl = '0;
    if (!s.error && s.part < PART_DONE) begin
      if (s.part == PART_LAST && s.seen) begin
        r = stamp_close(s);
      end else begin
        r.s.error = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ssa_dialogue_line_parser_top.sv */
// top level of the dialogue line parser: prefix check, field split, stamp and text filter
// depends on ssadlp_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one UTF-16 code unit per cycle (kind 0) or an end-of-line marker (kind 1). A character
// gives at most one result (text character or line break); an end of line gives an optional
// line break and then an event record, so it gives two results when the line holds text after
// its last line break. The first result of a transaction passes a register stage for the parse,
// one for the 17x32 timestamp multiply, one for the running totals, then an eight-entry result
// queue and the output register. in_stall rises only while eight producing transactions are in
// flight or queued, so with out_stall low the input runs at one transaction per clock unless
// end-of-line transactions that carry a break arrive faster than the output drains their second
// result. Configuration writes are taken at any cycle and belong in idle time.
module ssa_dialogue_line_parser_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 kind,
  input  wire logic [ssadlp_pkg::CODE_W-1:0]        code,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                result_kind,
  output logic [ssadlp_pkg::CODE_W-1:0]             text_code,
  output logic [ssadlp_pkg::TIME_W-1:0]             start_us,
  output logic signed [ssadlp_pkg::DUR_W-1:0]       duration_us,
  output logic                                      event_valid,
  output logic                                      last,
  input  wire logic                                 wr_en,
  input  wire logic [ssadlp_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire logic [ssadlp_pkg::CFG_DAT_W-1:0]     wr_data
);
  import ssadlp_pkg::*;

  // configuration
  logic [FCNT_W-1:0] field_count;
  logic [COL_W-1:0]  start_column;
  logic [COL_W-1:0]  end_column;
  logic [COL_W-1:0]  text_column;

  // line state
  logic [POS_W-1:0]   prefix_pos, prefix_pos_next;
  logic [FIELD_W-1:0] field_idx, field_idx_next;
  logic               rejected, rejected_next;
  tmode_t             tmode, tmode_next;
  logic [LEN_W-1:0]   line_len, line_len_next;
  logic               any_line, any_line_next;
  stamp_t             stamp [2];
  stamp_t             stamp_next [2];

  // parse outputs
  logic               accept;
  logic               prefix_ok;
  logic [FIELD_W-1:0] last_f;
  logic [COL_W-1:0]   field_col;
  logic [CODE_W-1:0]  lc;
  logic               append;
  entry_t             ent;
  logic               ent_en;
  logic               eol;
  close_t             cl [2];
  stamp_res_t         sr0, sr1;

  // pipeline
  logic               s1_ent_en, s1_eol;
  entry_t             s1_ent;
  close_t             s1_cl [2];
  logic               s2_ent_en, s2_eol;
  entry_t             s2_ent;
  logic               s2_en [2];
  logic [TIME_W-1:0]  s2_prod [2];
  logic [TIME_W-1:0]  total [2];
  logic [TIME_W-1:0]  sum [2];
  logic               s3_ent_en;
  entry_t             s3_ent;
  logic [TIME_W-1:0]  snap [2];

  // result queue and output
  fifo_entry_t        mem [FIFO_DEPTH];
  fifo_entry_t        wdata;
  fifo_entry_t        head;
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   reserved;
  logic               push, pop, ld;
  logic               split;
  rkind_t             out_kind;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (reserved >= CNT_W'(FIFO_DEPTH));
  assign prefix_ok = !rejected && (prefix_pos >= PREFIX_LEN);
  assign field_col = COL_W'(field_idx);

  always_comb begin
    if (field_count == '0) begin
      last_f = '0;
    end else if (field_count > FCNT_W'(MAX_FIELDS)) begin
      last_f = FIELD_W'(MAX_FIELDS - 1);
    end else begin
      last_f = FIELD_W'(field_count - FCNT_W'(1));
    end
  end

  assign lc = (code >= CH_UP_A && code <= CH_UP_Z) ? code + CASE_GAP : code;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count  <= RST_FIELD_COUNT;
      start_column <= RST_START_COLUMN;
      end_column   <= RST_END_COLUMN;
      text_column  <= RST_TEXT_COLUMN;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_FIELD_COUNT:  field_count  <= wr_data;
        CFG_START_COLUMN: start_column <= wr_data[COL_W-1:0];
        CFG_END_COLUMN:   end_column   <= wr_data[COL_W-1:0];
        CFG_TEXT_COLUMN:  text_column  <= wr_data[COL_W-1:0];
      endcase
    end
  end

  always_comb begin
    prefix_pos_next = prefix_pos;
    field_idx_next  = field_idx;
    rejected_next   = rejected;
    tmode_next      = tmode;
    line_len_next   = line_len;
    any_line_next   = any_line;
    stamp_next[0]   = stamp[0];
    stamp_next[1]   = stamp[1];
    cl[0]           = '0;
    cl[1]           = '0;
    sr0             = '0;
    sr1             = '0;
    append          = 1'b0;
    ent.brk_first   = 1'b0;
    ent.kind        = RK_TEXT;
    ent.code        = '0;
    ent.valid       = 1'b0;
    ent_en          = 1'b0;
    eol             = 1'b0;
    if (accept) begin
      if (kind) begin
        eol    = 1'b1;
        ent_en = 1'b1;
        if (prefix_ok) begin
          if (field_col == start_column) begin
            sr0           = stamp_end(stamp[0]);
            stamp_next[0] = sr0.s;
            cl[0]         = sr0.cl;
          end
          if (field_col == end_column) begin
            sr1           = stamp_end(stamp[1]);
            stamp_next[1] = sr1.s;
            cl[1]         = sr1.cl;
          end
        end
        ent.brk_first = (line_len != '0);
        ent.kind      = RK_RECORD;
        ent.valid     = prefix_ok && (field_idx == last_f)
                        && (stamp_next[0].part >= PART_DONE) && !stamp_next[0].error
                        && (stamp_next[1].part >= PART_DONE) && !stamp_next[1].error
                        && (any_line || (line_len != '0));
        prefix_pos_next = '0;
        field_idx_next  = '0;
        rejected_next   = 1'b0;
        tmode_next      = TM_NORMAL;
        line_len_next   = '0;
        any_line_next   = 1'b0;
        stamp_next[0]   = '0;
        stamp_next[1]   = '0;
      end else if (!rejected) begin
        if (!prefix_ok) begin
          if (lc == prefix_char(prefix_pos)) begin
            prefix_pos_next = prefix_pos + POS_W'(1);
          end else begin
            rejected_next = 1'b1;
          end
        end else if (code == CH_COMMA && field_idx < last_f) begin
          if (field_col == start_column) begin
            sr0           = stamp_end(stamp[0]);
            stamp_next[0] = sr0.s;
            cl[0]         = sr0.cl;
          end
          if (field_col == end_column) begin
            sr1           = stamp_end(stamp[1]);
            stamp_next[1] = sr1.s;
            cl[1]         = sr1.cl;
          end
          tmode_next     = TM_NORMAL;
          field_idx_next = field_idx + FIELD_W'(1);
        end else begin
          if (field_col == start_column) begin
            sr0           = stamp_char(stamp[0], code);
            stamp_next[0] = sr0.s;
            cl[0]         = sr0.cl;
          end
          if (field_col == end_column) begin
            sr1           = stamp_char(stamp[1], code);
            stamp_next[1] = sr1.s;
            cl[1]         = sr1.cl;
          end
          if (field_col == text_column) begin
            unique case (tmode)
              TM_BRACE: begin
                if (code == CH_RBRACE) begin
                  tmode_next = TM_NORMAL;
                end
              end
              TM_ESCAPE: begin
                tmode_next = TM_NORMAL;
                if (code == CH_LOW_N || code == CH_UP_N) begin
                  ent_en        = 1'b1;
                  ent.kind      = RK_BREAK;
                  line_len_next = '0;
                  any_line_next = 1'b1;
                end else if (code == CH_BSLASH) begin
                  append = 1'b1;
                end
              end
              TM_NORMAL: begin
                if (code == CH_LBRACE) begin
                  tmode_next = TM_BRACE;
                end else if (code == CH_BSLASH) begin
                  tmode_next = TM_ESCAPE;
                end else begin
                  append = 1'b1;
                end
              end
              default: tmode_next = TM_NORMAL;
            endcase
            if (append && line_len < LEN_W'(MAX_LINE_CHARS - 1)) begin
              ent_en        = 1'b1;
              ent.kind      = RK_TEXT;
              ent.code      = code;
              line_len_next = line_len + LEN_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pos <= '0;
      field_idx  <= '0;
      rejected   <= 1'b0;
      tmode      <= TM_NORMAL;
      line_len   <= '0;
      any_line   <= 1'b0;
      stamp[0]   <= '0;
      stamp[1]   <= '0;
    end else begin
      prefix_pos <= prefix_pos_next;
      field_idx  <= field_idx_next;
      rejected   <= rejected_next;
      tmode      <= tmode_next;
      line_len   <= line_len_next;
      any_line   <= any_line_next;
      stamp[0]   <= stamp_next[0];
      stamp[1]   <= stamp_next[1];
    end
  end

  // stage 1: parse result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ent_en <= 1'b0;
      s1_eol    <= 1'b0;
      s1_cl[0]  <= '0;
      s1_cl[1]  <= '0;
    end else begin
      s1_ent_en <= ent_en;
      s1_eol    <= eol;
      s1_cl[0]  <= cl[0];
      s1_cl[1]  <= cl[1];
    end
  end

  always_ff @(posedge clk) begin
    s1_ent <= ent;
  end

  // stage 2: scale closed numbers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ent_en <= 1'b0;
      s2_eol    <= 1'b0;
      s2_en[0]  <= 1'b0;
      s2_en[1]  <= 1'b0;
    end else begin
      s2_ent_en <= s1_ent_en;
      s2_eol    <= s1_eol;
      s2_en[0]  <= s1_cl[0].en;
      s2_en[1]  <= s1_cl[1].en;
    end
  end

  always_ff @(posedge clk) begin
    s2_ent     <= s1_ent;
    s2_prod[0] <= s1_cl[0].number * part_scale(s1_cl[0].part);
    s2_prod[1] <= s1_cl[1].number * part_scale(s1_cl[1].part);
  end

  // stage 3: running totals, snapshot at end of line
  assign sum[0] = total[0] + (s2_en[0] ? s2_prod[0] : '0);
  assign sum[1] = total[1] + (s2_en[1] ? s2_prod[1] : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      total[0]  <= '0;
      total[1]  <= '0;
      s3_ent_en <= 1'b0;
    end else begin
      s3_ent_en <= s2_ent_en;
      if (s2_eol) begin
        total[0] <= '0;
        total[1] <= '0;
      end else begin
        total[0] <= sum[0];
        total[1] <= sum[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_ent  <= s2_ent;
    snap[0] <= sum[0];
    snap[1] <= sum[1];
  end

  // result queue
  assign push = s3_ent_en;

  always_comb begin
    wdata.brk_first = s3_ent.brk_first;
    wdata.kind      = s3_ent.kind;
    wdata.code      = s3_ent.code;
    wdata.valid     = s3_ent.valid;
    wdata.start     = s3_ent.valid ? snap[0] : '0;
    wdata.dur       = s3_ent.valid ? ({1'b0, snap[1]} - {1'b0, snap[0]}) : '0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign head = mem[rd_ptr];
  assign ld   = (fill != '0) && (!out_valid || !out_stall);
  assign pop  = ld && !(head.brk_first && !split);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      reserved <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill     <= fill + CNT_W'(push) - CNT_W'(pop);
      reserved <= reserved + CNT_W'(accept && ent_en) - CNT_W'(pop);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      split     <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
      split     <= !pop;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      if (!pop) begin
        out_kind    <= RK_BREAK;
        text_code   <= '0;
        start_us    <= '0;
        duration_us <= '0;
        event_valid <= 1'b0;
        last        <= 1'b0;
      end else begin
        out_kind    <= head.kind;
        text_code   <= head.code;
        start_us    <= head.start;
        duration_us <= head.dur;
        event_valid <= head.valid;
        last        <= 1'b1;
      end
    end
  end

  assign result_kind = out_kind;

  a_fill_within_credit: assert property (@(posedge clk) disable iff (rst)
    fill <= reserved)
    else $error("queue fill exceeds reserved credit");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> fill < CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_split_holds_break: assert property (@(posedge clk) disable iff (rst)
    split |-> out_valid && !last && out_kind == RK_BREAK)
    else $error("pending record without leading break in output register");

  a_record_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == RK_RECORD |-> last)
    else $error("record result not marked last");

  a_eol_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    accept && kind |=> s1_eol && s1_ent_en)
    else $error("end of line did not reach stage one");

endmodule

`default_nettype wire
